// ===== hw/rtl/dnce_pkg.sv =====
// Shared constants, types and table functions for the double normal curve evaluator.
`timescale 1ns / 1ps

package dnce_pkg;

   localparam int AGE_W = 8;
   localparam int Q88_W = 16;
   localparam int VALUE_W = 24;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 16;

   // The fraction table holds values up to 1.0 in Q1.16, so it needs 17 bits.
   localparam int FRAC_W = 17;
   localparam int PROD_W = Q88_W + FRAC_W;

   localparam int MAX_AGE = 255;
   localparam int DEFAULT_FRAC_TABLE_BITS = 6;
   localparam int MAX_FRAC_TABLE_BITS = 10;

   localparam logic [Q88_W-1:0] PEAK_AGE_RESET = 16'd0;
   localparam logic [Q88_W-1:0] WIDTH_RESET = 16'd256;
   localparam logic [Q88_W-1:0] HEIGHT_RESET = 16'd256;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PEAK_AGE    = 8'd0,
      CSR_LEFT_WIDTH  = 8'd1,
      CSR_RIGHT_WIDTH = 8'd2,
      CSR_PEAK_HEIGHT = 8'd3
   } csr_index_type;

   // Floor square root of a 64-bit value, one result bit per pass.
   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem = v;
      res = 64'd0;
      bitv = 64'd1 << 62;
      for (int s = 0; s < 32; s++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Entry i of the 2^-(i / 2^bits) table in Q1.16, built from repeated
   // square roots of one half in Q2.30 and truncated products of them.
   function automatic logic [FRAC_W-1:0] frac_entry(input int bits, input int i);
      logic [63:0] root [MAX_FRAC_TABLE_BITS+1];
      logic [63:0] prod;
      root[0] = 64'd1 << 29;
      for (int k = 1; k <= MAX_FRAC_TABLE_BITS; k++) begin
         if (k <= bits) begin
            root[k] = int_sqrt(root[k-1] << 30);
         end else begin
            root[k] = 64'd0;
         end
      end
      prod = 64'd1 << 30;
      for (int j = 0; j < MAX_FRAC_TABLE_BITS; j++) begin
         if (j < bits && ((i >> j) & 1) == 1) begin
            prod = (prod * root[bits-j]) >> 30;
         end
      end
      return FRAC_W'(prod >> 14);
   endfunction

endpackage

// ===== hw/rtl/double_normal_curve_eval_unit.sv =====
// Top level of the double normal curve evaluator: front end, divider, square, exp2 and scale.
`timescale 1ns / 1ps

// Evaluates peak_height * 2^-(((age - peak_age) / width)^2) for one integer age per
// request, picking the left width below the peak and the right width at or above it.
// The unit takes one request per clock while no stalled result holds the pipeline; its
// divider resolves one quotient bit per stage over 16 stages. A stalled result holds the
// whole pipeline in place, so while rsp_stall is high with a result waiting,
// req_stall is high as well. The result is unsigned Q8.16.
// Configuration registers (unsigned Q8.8) are written through the csr port, which is
// always ready; write them only while no request is in flight. Zero widths and a zero
// height act as one LSB, and ages above the maximum age are clamped.
module double_normal_curve_eval_unit #(
   parameter int FRAC_TABLE_BITS = dnce_pkg::DEFAULT_FRAC_TABLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [dnce_pkg::AGE_W-1:0]           req_age,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dnce_pkg::VALUE_W-1:0]         rsp_curve_value,
   output logic                                 rsp_on_left_side,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dnce_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dnce_pkg::CSR_DATA_W-1:0]      csr_data
);
   import dnce_pkg::*;

   localparam int TableSize = 1 << FRAC_TABLE_BITS;
   localparam int DivSteps = Q88_W;
   localparam int ZeroShift = PROD_W - 8;
   localparam logic [AGE_W-1:0] AgeClamp = (MAX_AGE > 255) ? 8'd255 : AGE_W'(MAX_AGE);

   // Configuration registers.
   logic [Q88_W-1:0] peak_age_ff, left_width_ff, right_width_ff, peak_height_ff;
   logic [Q88_W-1:0] sig_left, sig_right, alpha;

   // Pipeline advance for every stage.
   logic adv;

   // Front end: clamp, compare to the peak, absolute distance.
   logic             s1_valid_ff, s1_left_ff;
   logic [Q88_W-1:0] s1_d_ff;
   logic [AGE_W-1:0] age_c;
   logic [Q88_W-1:0] age_q;
   logic             s1_left_in;
   logic [Q88_W-1:0] s1_d_in;

   // Divider stages. Stage 0 holds the starting remainder; dividend bits shift out
   // of the top of dq while quotient bits shift in at the bottom.
   logic             div_valid_ff [DivSteps+1];
   logic             div_left_ff  [DivSteps+1];
   logic             div_sat_ff   [DivSteps+1];
   logic [Q88_W-1:0] div_dq_ff    [DivSteps+1];
   logic [Q88_W-1:0] div_rem_ff   [DivSteps];
   logic [Q88_W-1:0] s1_sigma;
   logic             div0_sat_in;

   // Square, saturate, table lookup, scale, shift.
   logic                 sq_valid_ff, sq_left_ff;
   logic [2*Q88_W-1:0]   sq_ff, sq_in;
   logic [Q88_W-1:0]     q_val;
   logic                 zs_valid_ff, zs_left_ff;
   logic [Q88_W-1:0]     zs_ff, zs_in;
   logic                 tb_valid_ff, tb_left_ff;
   logic [FRAC_W-1:0]    tb_t_ff;
   logic [7:0]           tb_n_ff;
   logic [8+FRAC_TABLE_BITS-1:0] idx_wide;
   logic [FRAC_TABLE_BITS-1:0]   idx;
   logic [FRAC_W-1:0]    frac_rom [TableSize];
   logic                 mu_valid_ff, mu_left_ff;
   logic [PROD_W-1:0]    mu_prod_ff, mu_prod_in;
   logic [7:0]           mu_n_ff;
   logic                 rsp_valid_ff, rsp_left_ff;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [5:0]           shamt;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_age_ff    <= PEAK_AGE_RESET;
         left_width_ff  <= WIDTH_RESET;
         right_width_ff <= WIDTH_RESET;
         peak_height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PEAK_AGE:    peak_age_ff    <= csr_data;
            CSR_LEFT_WIDTH:  left_width_ff  <= csr_data;
            CSR_RIGHT_WIDTH: right_width_ff <= csr_data;
            CSR_PEAK_HEIGHT: peak_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign sig_left  = (left_width_ff == '0) ? Q88_W'(1) : left_width_ff;
   assign sig_right = (right_width_ff == '0) ? Q88_W'(1) : right_width_ff;
   assign alpha     = (peak_height_ff == '0) ? Q88_W'(1) : peak_height_ff;

   // ---------------------------------------------------------------- flow control
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---------------------------------------------------------------- front end
   always_comb begin
      age_c      = (req_age > AgeClamp) ? AgeClamp : req_age;
      age_q      = {age_c, 8'd0};
      s1_left_in = age_q < peak_age_ff;
      s1_d_in    = s1_left_in ? (peak_age_ff - age_q) : (age_q - peak_age_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_left_ff <= s1_left_in;
         s1_d_ff    <= s1_d_in;
      end
   end

   // ---------------------------------------------------------------- divider
   // The quotient exceeds Q8.8 exactly when the integer part of d reaches sigma.
   always_comb begin
      s1_sigma    = s1_left_ff ? sig_left : sig_right;
      div0_sat_in = {8'd0, s1_d_ff[15:8]} >= s1_sigma;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         div_valid_ff[0] <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_left_ff[0] <= s1_left_ff;
         div_sat_ff[0]  <= div0_sat_in;
         div_rem_ff[0]  <= {8'd0, s1_d_ff[15:8]};
         div_dq_ff[0]   <= {s1_d_ff[7:0], 8'd0};
      end
   end

   for (genvar k = 1; k <= DivSteps; k++) begin : g_div
      logic [Q88_W:0]   rem_sh;
      logic [Q88_W-1:0] sig;
      logic             ge;
      logic [Q88_W-1:0] rem_in;
      logic [Q88_W-1:0] dq_in;

      always_comb begin
         rem_sh = {div_rem_ff[k-1], div_dq_ff[k-1][Q88_W-1]};
         sig    = div_left_ff[k-1] ? sig_left : sig_right;
         ge     = rem_sh >= {1'b0, sig};
         rem_in = ge ? Q88_W'(rem_sh - {1'b0, sig}) : rem_sh[Q88_W-1:0];
         dq_in  = {div_dq_ff[k-1][Q88_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            div_valid_ff[k] <= div_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_left_ff[k] <= div_left_ff[k-1];
            div_sat_ff[k]  <= div_sat_ff[k-1];
            div_dq_ff[k]   <= dq_in;
         end
      end

      if (k < DivSteps) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               div_rem_ff[k] <= rem_in;
            end
         end
      end
   end

   // ---------------------------------------------------------------- square
   always_comb begin
      q_val = div_sat_ff[DivSteps] ? {Q88_W{1'b1}} : div_dq_ff[DivSteps];
      sq_in = q_val * q_val;
   end

   // ---------------------------------------------------------------- saturate z
   assign zs_in = (sq_ff[2*Q88_W-1:24] != '0) ? {Q88_W{1'b1}} : sq_ff[23:8];

   // ---------------------------------------------------------------- table lookup
   for (genvar i = 0; i < TableSize; i++) begin : g_rom
      assign frac_rom[i] = frac_entry(FRAC_TABLE_BITS, i);
   end

   always_comb begin
      idx_wide = {zs_ff[7:0], {FRAC_TABLE_BITS{1'b0}}};
      idx      = idx_wide[8+FRAC_TABLE_BITS-1:8];
   end

   // ---------------------------------------------------------------- scale and shift
   assign mu_prod_in = PROD_W'(alpha) * PROD_W'(tb_t_ff);

   always_comb begin
      shamt = 6'd8 + mu_n_ff[5:0];
      if (mu_n_ff >= 8'(ZeroShift)) begin
         rsp_value_in = '0;
      end else begin
         rsp_value_in = VALUE_W'(mu_prod_ff >> shamt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         zs_valid_ff  <= 1'b0;
         tb_valid_ff  <= 1'b0;
         mu_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         sq_valid_ff  <= div_valid_ff[DivSteps];
         zs_valid_ff  <= sq_valid_ff;
         tb_valid_ff  <= zs_valid_ff;
         mu_valid_ff  <= tb_valid_ff;
         rsp_valid_ff <= mu_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_left_ff   <= div_left_ff[DivSteps];
         sq_ff        <= sq_in;
         zs_left_ff   <= sq_left_ff;
         zs_ff        <= zs_in;
         tb_left_ff   <= zs_left_ff;
         tb_t_ff      <= frac_rom[idx];
         tb_n_ff      <= zs_ff[15:8];
         mu_left_ff   <= tb_left_ff;
         mu_prod_ff   <= mu_prod_in;
         mu_n_ff      <= tb_n_ff;
         rsp_left_ff  <= mu_left_ff;
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_curve_value  = rsp_value_ff;
   assign rsp_on_left_side = rsp_left_ff;

endmodule
